/* hdl/dsa_pkg.sv */
`timescale 1ns / 1ps
// Types, codes and fixed widths for the descriptor slot allocator.
// No dependencies; imported by every other module of the block but dsa_ram.
package dsa_pkg;

   localparam int unsigned POOLS      = 4;
   localparam int unsigned DATA_W     = 64;
   localparam int unsigned STRIDE_W   = 11;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_USER_W = 3;
   localparam int unsigned CSR_ADDR_W = 6;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

   typedef enum logic [0:0] {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      POOL_RESOURCE = 2'd0,
      POOL_SAMPLER  = 2'd1,
      POOL_TARGET   = 2'd2,
      POOL_DEPTH    = 2'd3
   } pool_type;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_EXHAUSTED    = 3'd1,
      STATUS_BELOW_BASE   = 3'd2,
      STATUS_NEVER_ISSUED = 3'd3,
      STATUS_STACK_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_BASE_RESOURCE   = 3'd0,
      REG_BASE_SAMPLER    = 3'd1,
      REG_BASE_TARGET     = 3'd2,
      REG_BASE_DEPTH      = 3'd3,
      REG_STRIDE_RESOURCE = 3'd4,
      REG_STRIDE_SAMPLER  = 3'd5,
      REG_STRIDE_TARGET   = 3'd6,
      REG_STRIDE_DEPTH    = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [POOLS-1:0][DATA_W-1:0]   base;
      logic [POOLS-1:0][STRIDE_W-1:0] stride;
   } cfg_type;

   // classified request: offset is handle minus pool base, below marks a borrow
   typedef struct packed {
      kind_type          kind;
      pool_type          pool;
      logic              below;
      logic [DATA_W-1:0] offset;
   } cmd_type;

endpackage

/* hdl/dsa_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/dsa_csr.sv */
`timescale 1ns / 1ps
// APB-style register file holding pool bases and strides.
// Depends on dsa_pkg.
module dsa_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dsa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dsa_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [dsa_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready,
   output dsa_pkg::cfg_type                cfg
);
   import dsa_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_idx;
   logic        wr_en;

   assign reg_idx    = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BASE_RESOURCE:   cfg_in.base[POOL_RESOURCE]   = csr_pwdata;
            REG_BASE_SAMPLER:    cfg_in.base[POOL_SAMPLER]    = csr_pwdata;
            REG_BASE_TARGET:     cfg_in.base[POOL_TARGET]     = csr_pwdata;
            REG_BASE_DEPTH:      cfg_in.base[POOL_DEPTH]      = csr_pwdata;
            REG_STRIDE_RESOURCE: cfg_in.stride[POOL_RESOURCE] = csr_pwdata[STRIDE_W-1:0];
            REG_STRIDE_SAMPLER:  cfg_in.stride[POOL_SAMPLER]  = csr_pwdata[STRIDE_W-1:0];
            REG_STRIDE_TARGET:   cfg_in.stride[POOL_TARGET]   = csr_pwdata[STRIDE_W-1:0];
            REG_STRIDE_DEPTH:    cfg_in.stride[POOL_DEPTH]    = csr_pwdata[STRIDE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BASE_RESOURCE:   csr_prdata = cfg_ff.base[POOL_RESOURCE];
         REG_BASE_SAMPLER:    csr_prdata = cfg_ff.base[POOL_SAMPLER];
         REG_BASE_TARGET:     csr_prdata = cfg_ff.base[POOL_TARGET];
         REG_BASE_DEPTH:      csr_prdata = cfg_ff.base[POOL_DEPTH];
         REG_STRIDE_RESOURCE: csr_prdata = DATA_W'(cfg_ff.stride[POOL_RESOURCE]);
         REG_STRIDE_SAMPLER:  csr_prdata = DATA_W'(cfg_ff.stride[POOL_SAMPLER]);
         REG_STRIDE_TARGET:   csr_prdata = DATA_W'(cfg_ff.stride[POOL_TARGET]);
         REG_STRIDE_DEPTH:    csr_prdata = DATA_W'(cfg_ff.stride[POOL_DEPTH]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOLS; i++) begin
            cfg_ff.base[i]   <= '0;
            cfg_ff.stride[i] <= STRIDE_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/dsa_front.sv */
`timescale 1ns / 1ps
// Request intake: takes a transfer, subtracts the pool base and flags
// handles below it. Depends on dsa_pkg.
module dsa_front (
   input  logic                            clock,
   input  logic                            reset,
   input  dsa_pkg::cfg_type                cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dsa_pkg::DATA_W-1:0]      req_tdata,
   input  logic [dsa_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            cmd_valid,
   input  logic                            cmd_ready,
   output dsa_pkg::cmd_type                cmd
);
   import dsa_pkg::*;

   logic            valid_ff, valid_in;
   cmd_type         cmd_ff, cmd_in;
   pool_type        pool;
   logic [DATA_W:0] diff;

   assign pool       = pool_type'(req_tuser[2:1]);
   assign diff       = {1'b0, req_tdata} - {1'b0, cfg.base[pool]};
   assign req_tready = !valid_ff || cmd_ready;

   always_comb begin
      valid_in = valid_ff && !cmd_ready;
      cmd_in   = cmd_ff;
      if (req_tvalid && req_tready) begin
         valid_in      = 1'b1;
         cmd_in.kind   = kind_type'(req_tuser[0]);
         cmd_in.pool   = pool;
         cmd_in.below  = diff[DATA_W];
         cmd_in.offset = diff[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

/* hdl/dsa_queue.sv */
`timescale 1ns / 1ps
// Short command queue between intake and execution.
// Depends on dsa_pkg.
module dsa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dsa_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output dsa_pkg::cmd_type out_cmd
);
   import dsa_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign in_ready  = (count_ff != CW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entry_ff[rptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= in_cmd;
      end
   end

endmodule

/* hdl/dsa_back.sv */
`timescale 1ns / 1ps
// Execution sequencer: free stacks, bump counters, slot multiply and
// bit-serial slot divide, result register. Depends on dsa_pkg, dsa_ram.
module dsa_back #(
   parameter int CAP_RESOURCE = 4096,
   parameter int CAP_SAMPLER  = 2048,
   parameter int CAP_TARGET   = 256,
   parameter int CAP_DEPTH    = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  dsa_pkg::cfg_type                cfg,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  dsa_pkg::cmd_type                cmd,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dsa_pkg::DATA_W-1:0]      rsp_tdata,
   output logic [dsa_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import dsa_pkg::*;

   localparam int CAP_AB  = (CAP_RESOURCE > CAP_SAMPLER) ? CAP_RESOURCE : CAP_SAMPLER;
   localparam int CAP_CD  = (CAP_TARGET > CAP_DEPTH) ? CAP_TARGET : CAP_DEPTH;
   localparam int CAP_MAX = (CAP_AB > CAP_CD) ? CAP_AB : CAP_CD;
   localparam int CW      = $clog2(CAP_MAX + 1);
   localparam int PW      = CW + STRIDE_W;
   localparam int SW      = $clog2(CW + 1);
   localparam logic [POOLS-1:0][CW-1:0] CAP_VEC = {
      CW'(CAP_DEPTH), CW'(CAP_TARGET), CW'(CAP_SAMPLER), CW'(CAP_RESOURCE)
   };

   typedef enum logic [3:0] {
      S_IDLE, S_POP_WAIT, S_MUL, S_ADD, S_CHECK_MUL, S_CHECK, S_DIV, S_PUSH, S_OUT
   } state_type;

   state_type                state_ff, state_in;
   pool_type                 pool_ff, pool_in;
   logic [DATA_W-1:0]        offset_ff, offset_in;
   logic [CW-1:0]            slot_ff, slot_in;
   logic [PW-1:0]            prod_ff, prod_in;
   logic [PW-1:0]            rem_ff, rem_in;
   logic [PW-1:0]            div_ff, div_in;
   logic [CW-1:0]            quo_ff, quo_in;
   logic [SW-1:0]            step_ff, step_in;
   logic [DATA_W-1:0]        res_handle_ff, res_handle_in;
   status_type               res_status_ff, res_status_in;
   logic [POOLS-1:0][CW-1:0] fc_ff, fc_in;
   logic [POOLS-1:0][CW-1:0] bump_ff, bump_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_handle_ff, rsp_handle_in;
   status_type               rsp_status_ff, rsp_status_in;

   logic [POOLS-1:0][CW-1:0] fc_m1;
   logic [POOLS-1:0][CW-1:0] rd_slot;
   logic [POOLS-1:0]         stack_we;
   logic [STRIDE_W-1:0]      stride_sel;
   logic [CW-1:0]            mul_a;
   logic [PW-1:0]            mul_p;
   logic [PW:0]              div_diff;

   assign stride_sel = cfg.stride[pool_ff];
   assign mul_a      = (state_ff == S_MUL) ? slot_ff : bump_ff[pool_ff];
   assign mul_p      = mul_a * stride_sel;
   assign div_diff   = {1'b0, rem_ff} - {1'b0, div_ff};
   assign cmd_ready  = (state_ff == S_IDLE);

   for (genvar g = 0; g < POOLS; g++) begin : g_stack
      localparam int CAP_G = (g == 0) ? CAP_RESOURCE : (g == 1) ? CAP_SAMPLER :
                             (g == 2) ? CAP_TARGET : CAP_DEPTH;
      localparam int AW_G  = (CAP_G > 1) ? $clog2(CAP_G) : 1;
      logic [AW_G-1:0] rdata;

      assign fc_m1[g]    = fc_ff[g] - 1'b1;
      assign stack_we[g] = (state_ff == S_PUSH) && (pool_ff == pool_type'(g));

      dsa_ram #(
         .WIDTH (AW_G),
         .DEPTH (CAP_G)
      ) u_ram (
         .clock (clock),
         .we    (stack_we[g]),
         .waddr (fc_ff[g][AW_G-1:0]),
         .wdata (quo_ff[AW_G-1:0]),
         .raddr (fc_m1[g][AW_G-1:0]),
         .rdata (rdata)
      );

      assign rd_slot[g] = CW'(rdata);
   end

   always_comb begin
      state_in      = state_ff;
      pool_in       = pool_ff;
      offset_in     = offset_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      res_handle_in = res_handle_ff;
      res_status_in = res_status_ff;
      fc_in         = fc_ff;
      bump_in       = bump_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               pool_in       = cmd.pool;
               offset_in     = cmd.offset;
               res_handle_in = '0;
               res_status_in = STATUS_OK;
               if (cmd.kind == KIND_ALLOC) begin
                  if (fc_ff[cmd.pool] != '0) begin
                     fc_in[cmd.pool] = fc_m1[cmd.pool];
                     state_in        = S_POP_WAIT;
                  end else if (bump_ff[cmd.pool] < CAP_VEC[cmd.pool]) begin
                     slot_in           = bump_ff[cmd.pool];
                     bump_in[cmd.pool] = bump_ff[cmd.pool] + 1'b1;
                     state_in          = S_MUL;
                  end else begin
                     res_status_in = STATUS_EXHAUSTED;
                     state_in      = S_OUT;
                  end
               end else if (cmd.below) begin
                  res_status_in = STATUS_BELOW_BASE;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_CHECK_MUL;
               end
            end
         end
         S_POP_WAIT: begin
            slot_in  = rd_slot[pool_ff];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = mul_p;
            state_in = S_ADD;
         end
         S_ADD: begin
            res_handle_in = cfg.base[pool_ff] + DATA_W'(prod_ff);
            state_in      = S_OUT;
         end
         S_CHECK_MUL: begin
            prod_in  = mul_p;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (offset_ff >= DATA_W'(prod_ff)) begin
               res_status_in = STATUS_NEVER_ISSUED;
               state_in      = S_OUT;
            end else if (fc_ff[pool_ff] >= CAP_VEC[pool_ff]) begin
               res_status_in = STATUS_STACK_FULL;
               state_in      = S_OUT;
            end else begin
               rem_in   = offset_ff[PW-1:0];
               div_in   = PW'(stride_sel) << (CW - 1);
               quo_in   = '0;
               step_in  = SW'(CW);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_diff[PW]) begin
               rem_in = div_diff[PW-1:0];
            end
            quo_in  = {quo_ff[CW-2:0], !div_diff[PW]};
            div_in  = div_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == SW'(1)) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            fc_in[pool_ff] = fc_ff[pool_ff] + 1'b1;
            state_in       = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = res_handle_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fc_ff        <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pool_ff       <= pool_in;
      offset_ff     <= offset_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      res_handle_ff <= res_handle_in;
      res_status_ff <= res_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_handle_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_status_ff);

endmodule

/* hdl/descriptor_slot_allocator_top.sv */
`timescale 1ns / 1ps
// Descriptor slot allocator top level: register file, intake, command queue
// and execution sequencer. Depends on dsa_pkg and all dsa_* modules.
//
//   channel  direction  handshake            payload
//   req_     in         tvalid/tready        tdata handle_in; tuser kind, pool
//   rsp_     out        tvalid/tready        tdata handle_out; tuser status
//   csr_     in         psel/penable/pready  8 x 64-bit registers at 8*index
//
// Allocate: pop a freed slot from RAM or take the bump counter, then multiply
// by the stride and add the pool base. Free: multiply, check, then a quotient
// loop of one bit per cycle over CW = clog2(largest capacity + 1) bits, then push.
// Synchronous reset clears counters and handshakes; stacks hold no reset value.
// Intake and sequencer stall independently across a two-entry queue; a held
// result does not block the next request from being started.
module descriptor_slot_allocator_top #(
   parameter int CAP_RESOURCE = 4096,
   parameter int CAP_SAMPLER  = 2048,
   parameter int CAP_TARGET   = 256,
   parameter int CAP_DEPTH    = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [dsa_pkg::DATA_W-1:0]      req_tdata,   // [63:0] handle_in
   input  logic [dsa_pkg::REQ_USER_W-1:0]  req_tuser,   // [0] kind, [2:1] pool
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [dsa_pkg::DATA_W-1:0]      rsp_tdata,   // [63:0] handle_out
   output logic [dsa_pkg::RSP_USER_W-1:0]  rsp_tuser,   // [2:0] status
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dsa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [dsa_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [dsa_pkg::DATA_W-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import dsa_pkg::*;

   cfg_type cfg;
   cmd_type front_cmd, queue_cmd;
   logic    front_valid, front_ready, queue_valid, queue_ready;

   dsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   dsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_cmd   (queue_cmd)
   );

   dsa_back #(
      .CAP_RESOURCE (CAP_RESOURCE),
      .CAP_SAMPLER  (CAP_SAMPLER),
      .CAP_TARGET   (CAP_TARGET),
      .CAP_DEPTH    (CAP_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (queue_valid),
      .cmd_ready  (queue_ready),
      .cmd        (queue_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
